### rtl/core/qvr_pkg.sv
// Shared types, constants and the arctangent table for the quaternion rotation pipeline.
// Used by qvr_cordic and quaternion_vector_rotation_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // Default CORDIC iteration count and the length of the arctangent table
    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES        = 24;

    // Field widths
    localparam int POINT_W = 32;
    localparam int AXIS_W  = 16;
    localparam int ANGLE_W = 16;

    // CORDIC datapath: x and y in Q4.30, angle in degrees Q.24
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Half-angle reduction bounds, in 1/128 degree steps (90 and 180 degrees)
    localparam logic signed [ANGLE_W:0] HALF_QUARTER  = 17'sd11520;
    localparam logic signed [ANGLE_W:0] HALF_HALFTURN = 17'sd23040;

    // Fraction bits of the unit quaternion and its inverse
    localparam int UNIT_SHIFT = 24;

    // Fault codes carried on m_tuser
    typedef enum logic [1:0] {
        FAULT_OK        = 2'd0,
        FAULT_ZERO_NORM = 2'd1,
        FAULT_SATURATED = 2'd2
    } fault_t;

    // atan(2^-i) in degrees, Q.24
    function automatic logic signed [CORDIC_W-1:0] atan_q24(input int idx);
        case (idx)
            0:       return 34'sd754974720;
            1:       return 34'sd445687602;
            2:       return 34'sd235489088;
            3:       return 34'sd119537938;
            4:       return 34'sd60000934;
            5:       return 34'sd30029717;
            6:       return 34'sd15018523;
            7:       return 34'sd7509720;
            8:       return 34'sd3754917;
            9:       return 34'sd1877466;
            10:      return 34'sd938734;
            11:      return 34'sd469367;
            12:      return 34'sd234684;
            13:      return 34'sd117342;
            14:      return 34'sd58671;
            15:      return 34'sd29335;
            16:      return 34'sd14668;
            17:      return 34'sd7334;
            18:      return 34'sd3667;
            19:      return 34'sd1833;
            20:      return 34'sd917;
            21:      return 34'sd458;
            22:      return 34'sd229;
            23:      return 34'sd115;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/qvr_cordic.sv
// Pipelined rotation-mode CORDIC: half-angle reduction, one stage per iteration, sign fix-up.
// Depends on qvr_pkg. Carries an opaque sideband word alongside each transaction.
`timescale 1ns / 1ps
`default_nettype none

module qvr_cordic #(
    parameter int ITERATIONS = qvr_pkg::TRIG_ITERATIONS_DEF,
    parameter int SIDE_W     = 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [qvr_pkg::ANGLE_W-1:0]         angle,
    input  wire logic [SIDE_W-1:0]                   side_in,
    output logic                                     out_valid,
    output logic [qvr_pkg::CORDIC_W-1:0]             cos_q30,
    output logic [qvr_pkg::CORDIC_W-1:0]             sin_q30,
    output logic [SIDE_W-1:0]                        side_out
);

    localparam int STEPS = (ITERATIONS < qvr_pkg::ATAN_ENTRIES) ? ITERATIONS
                                                                : qvr_pkg::ATAN_ENTRIES;
    localparam int CW = qvr_pkg::CORDIC_W;
    localparam int AW = qvr_pkg::ANGLE_W;

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [CW-1:0] z_reg [0:STEPS];
    logic                 flip_reg [0:STEPS];
    logic [SIDE_W-1:0]    side_reg [0:STEPS];
    logic [STEPS:0]       vld_reg;

    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    logic [SIDE_W-1:0]    oside_reg;
    logic                 ovld_reg;

    logic signed [AW:0]   h_ext;
    logic signed [AW:0]   h_red;
    logic                 flip_next;
    logic signed [CW-1:0] z_next;

    // Fold the half angle into [-90, 90] degrees and note the sign flip
    always_comb
    begin
        h_ext     = {angle[AW-1], angle};
        h_red     = h_ext;
        flip_next = 1'b0;
        if (h_ext > qvr_pkg::HALF_QUARTER)
        begin
            h_red     = h_ext - qvr_pkg::HALF_HALFTURN;
            flip_next = 1'b1;
        end
        else if (h_ext < -qvr_pkg::HALF_QUARTER)
        begin
            h_red     = h_ext + qvr_pkg::HALF_HALFTURN;
            flip_next = 1'b1;
        end
        z_next = {h_red, 17'd0};
    end

    // Load the first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= qvr_pkg::CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
            side_reg[0] <= side_in;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[STEPS-1:0], in_valid};
            ovld_reg <= vld_reg[STEPS];
        end
    end

    // One micro-rotation per stage: x moves by y >> i, y by x >> i
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [CW-1:0] ATAN = qvr_pkg::atan_q24(i);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // Undo the half-turn fold by negating both results
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg   <= flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
            sin_reg   <= flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
            oside_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = ovld_reg;
    assign cos_q30   = cos_reg;
    assign sin_q30   = sin_reg;
    assign side_out  = oside_reg;

endmodule

`default_nettype wire

### rtl/core/qvr_div.sv
// Pipelined restoring divider, several signed numerators over one shared positive divisor.
// One quotient bit per stage, truncation toward zero. Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module qvr_div #(
    parameter int LANES  = 4,
    parameter int NUM_W  = 56,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 26,
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               out_valid,
    output logic [LANES-1:0][Q_W:0]            quo,
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [LANES-1:0][REM_W-1:0] rem_reg  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]   q_reg    [0:Q_W];
    logic [LANES-1:0]            neg_reg  [0:Q_W];
    logic [DEN_W-1:0]            den_reg  [0:Q_W];
    logic [SIDE_W-1:0]           side_reg [0:Q_W];
    logic [Q_W:0]                vld_reg;

    logic [LANES-1:0][Q_W:0]     quo_reg;
    logic [SIDE_W-1:0]           oside_reg;
    logic                        ovld_reg;

    logic [LANES-1:0][NUM_W-1:0] mag;
    logic [LANES-1:0]            neg;

    // Split each numerator into sign and magnitude
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            neg[l] = num[l][NUM_W-1];
            mag[l] = neg[l] ? (~num[l] + 1'b1) : num[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= REM_W'(mag[l]);
            end
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[Q_W-1:0], in_valid};
            ovld_reg <= vld_reg[Q_W];
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < Q_W; j++)
    begin : g_bit
        localparam int B = Q_W - 1 - j;
        logic [REM_W-1:0]            sub;
        logic [LANES-1:0][REM_W-1:0] rem_next;
        logic [LANES-1:0][Q_W-1:0]   q_next;

        assign sub = REM_W'(den_reg[j]) << B;

        always_comb
        begin
            rem_next = rem_reg[j];
            q_next   = q_reg[j];
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_reg[j][l] >= sub)
                begin
                    rem_next[l]  = rem_reg[j][l] - sub;
                    q_next[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
                neg_reg[j+1]  <= neg_reg[j];
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // Restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                quo_reg[l] <= neg_reg[Q_W][l] ? (~{1'b0, q_reg[Q_W][l]} + 1'b1)
                                              : {1'b0, q_reg[Q_W][l]};
            end
            oside_reg <= side_reg[Q_W];
        end
    end

    assign out_valid = ovld_reg;
    assign quo       = quo_reg;
    assign side_out  = oside_reg;

endmodule

`default_nettype wire

### rtl/core/quaternion_vector_rotation_top.sv
// Top level of the quaternion rotation pipeline: stream ports, norm, inverse, Hamilton products.
// Depends on qvr_pkg, qvr_cordic and qvr_div.
`timescale 1ns / 1ps
`default_nettype none

// Rotates a Q16.16 quaternion by a rotation built from a Q2.14 axis and an angle in 1/64 degree
// steps, returning q*p*q^-1 with a fault code on m_tuser (zero norm gives zeros, overflow
// clamps). The block is a fixed pipeline with no state between transactions: it takes one
// transaction every cycle while the pipeline is not stalled, and each result passes through
// the CORDIC stages, the 32 stages of the square root and the two 28-stage dividers before
// m_tvalid rises for it. One enable moves the whole pipeline: it stalls only while the output
// register holds a result that m_tready has not taken, so s_tready follows m_tready then and
// is high otherwise. No clearing pass follows reset.
module quaternion_vector_rotation_top #(
    parameter int TRIG_ITERATIONS = qvr_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // point_w, point_x, point_y, point_z, axis_x, axis_y, axis_z, angle_deg
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rotated_w, rotated_x, rotated_y, rotated_z
    output logic [127:0]      m_tdata,
    // fault
    output logic [1:0]        m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready
);

    localparam int PW  = qvr_pkg::POINT_W;
    localparam int CW  = qvr_pkg::CORDIC_W;
    localparam int US  = qvr_pkg::UNIT_SHIFT;
    localparam int RW  = 32;    // rotation quaternion, Q.28
    localparam int UW  = 27;    // unit quaternion and inverse, Q.24
    localparam int MW  = 29;    // squared norm of the unit quaternion, Q.24
    localparam int QB  = 26;    // quotient bits of both dividers
    localparam int SQS = 32;    // square root stages
    localparam int T1W = 35;    // first product terms
    localparam int TW  = 37;    // intermediate quaternion
    localparam int T2W = 40;    // second product terms
    localparam int HW  = 42;    // Hamilton sums

    // Clamp bounds of a 32-bit signed result
    localparam logic signed [HW-1:0] SAT_HI = 42'sd2147483647;
    localparam logic signed [HW-1:0] SAT_LO = -42'sd2147483648;

    logic en;

    // Sum the sixteen product terms into a Hamilton product
    function automatic logic [3:0][HW-1:0] hamilton(input logic [3:0][3:0][T2W-1:0] pt);
        logic signed [HW-1:0] e [0:3][0:3];
        logic [3:0][HW-1:0]   o;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                e[i][j] = HW'($signed(pt[i][j]));
            end
        end
        o[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        o[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        o[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
        o[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
        return o;
    endfunction

    // Output register and global pipeline enable
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic [1:0]   out_fault_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

    // Cos and sin of the half angle; the point and axis ride along
    logic            cv;
    logic [CW-1:0]   cos_q30;
    logic [CW-1:0]   sin_q30;
    logic [175:0]    cside;

    qvr_cordic #(
        .ITERATIONS (TRIG_ITERATIONS),
        .SIDE_W     (176)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .angle     (s_tdata[191:176]),
        .side_in   (s_tdata[175:0]),
        .out_valid (cv),
        .cos_q30   (cos_q30),
        .sin_q30   (sin_q30),
        .side_out  (cside)
    );

    // Build the rotation quaternion in Q.28
    logic signed [49:0]     axp [0:2];
    logic [3:0][RW-1:0]     r_next;
    logic [3:0][RW-1:0]     r_reg;
    logic [127:0]           rp_reg;
    logic                   r_valid_reg;

    always_comb
    begin
        r_next[0] = cos_q30[CW-1:2];
        for (int k = 0; k < 3; k++)
        begin
            axp[k]      = $signed(cside[128 + 16*k +: 16]) * $signed(sin_q30);
            r_next[k+1] = axp[k][47:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg  <= r_next;
            rp_reg <= cside[127:0];
        end
    end

    // Square each component
    logic signed [63:0]     sq_next [0:3];
    logic [3:0][63:0]       sq_reg;
    logic [3:0][RW-1:0]     qr_reg;
    logic [127:0]           qp_reg;
    logic                   q_valid_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sq_next[k] = $signed(r_reg[k]) * $signed(r_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            qr_reg <= r_reg;
            qp_reg <= rp_reg;
        end
    end

    // Integer square root of the squared norm, one result bit per stage
    logic [63:0]   srem_reg  [0:SQS];
    logic [63:0]   sroot_reg [0:SQS];
    logic [255:0]  sside_reg [0:SQS];
    logic [SQS:0]  svld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            sroot_reg[0] <= '0;
            sside_reg[0] <= {qr_reg, qp_reg};
        end
    end

    for (genvar k = 0; k < SQS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQS - 1 - k));
        logic [63:0] trial;

        assign trial = sroot_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (srem_reg[k] >= trial)
                begin
                    srem_reg[k+1]  <= srem_reg[k] - trial;
                    sroot_reg[k+1] <= (sroot_reg[k] >> 1) + BIT;
                end
                else
                begin
                    srem_reg[k+1]  <= srem_reg[k];
                    sroot_reg[k+1] <= sroot_reg[k] >> 1;
                end
                sside_reg[k+1] <= sside_reg[k];
            end
        end
    end

    // Normalise: u = r * 2^24 / norm
    logic [30:0]             nrm;
    logic                    nrm_zero;
    logic [3:0][55:0]        d1_num;
    logic                    d1_valid;
    logic [3:0][QB:0]        d1_quo;
    logic [128:0]            d1_side;

    assign nrm      = sroot_reg[SQS][30:0];
    assign nrm_zero = (nrm == '0);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d1_num[k] = {sside_reg[SQS][128 + RW*k +: RW], {US{1'b0}}};
        end
    end

    qvr_div #(
        .LANES  (4),
        .NUM_W  (56),
        .DEN_W  (31),
        .Q_W    (QB),
        .SIDE_W (129)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (svld_reg[SQS]),
        .num       (d1_num),
        .den       (nrm),
        .side_in   ({nrm_zero, sside_reg[SQS][127:0]}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    // Square the unit quaternion components
    logic signed [53:0]     us_next [0:3];
    logic [3:0][53:0]       us_reg;
    logic [3:0][UW-1:0]     su_reg;
    logic [127:0]           sp_reg;
    logic                   sz_reg;
    logic                   sq_valid_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            us_next[k] = $signed(d1_quo[k]) * $signed(d1_quo[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                us_reg[k] <= us_next[k];
            end
            su_reg <= d1_quo;
            sp_reg <= d1_side[127:0];
            sz_reg <= d1_side[128];
        end
    end

    // Squared norm m, Q.24; flag a zero divisor
    logic [55:0]            msum;
    logic [MW-1:0]          m_next;
    logic [MW-1:0]          nm_reg;
    logic [3:0][UW-1:0]     nu_reg;
    logic [127:0]           np_reg;
    logic                   nz_reg;
    logic                   n_valid_reg;

    always_comb
    begin
        msum   = 56'(us_reg[0]) + 56'(us_reg[1]) + 56'(us_reg[2]) + 56'(us_reg[3]);
        m_next = msum[US + MW - 1:US];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg <= m_next;
            nu_reg <= su_reg;
            np_reg <= sp_reg;
            nz_reg <= sz_reg || (m_next == '0);
        end
    end

    // Inverse: conjugate * 2^24 / m
    logic [3:0][UW-1:0]     conj;
    logic [3:0][50:0]       d2_num;
    logic                   d2_valid;
    logic [3:0][QB:0]       d2_quo;
    logic [236:0]           d2_side;

    always_comb
    begin
        conj[0] = nu_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            conj[k] = ~nu_reg[k] + 1'b1;
        end
        for (int k = 0; k < 4; k++)
        begin
            d2_num[k] = {conj[k], {US{1'b0}}};
        end
    end

    qvr_div #(
        .LANES  (4),
        .NUM_W  (51),
        .DEN_W  (MW),
        .Q_W    (QB),
        .SIDE_W (237)
    ) u_div_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .num       (d2_num),
        .den       (nm_reg),
        .side_in   ({nz_reg, nu_reg, np_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    // First Hamilton product u*p: partial products
    logic [3:0][UW-1:0]     hu;
    logic [3:0][PW-1:0]     hp;
    logic signed [58:0]     pr1 [0:3][0:3];
    logic [3:0][3:0][T1W-1:0] h1_pt_reg;
    logic [3:0][UW-1:0]     h1_v_reg;
    logic                   h1_z_reg;
    logic                   h1_valid_reg;

    assign hp = d2_side[127:0];
    assign hu = d2_side[235:128];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pr1[i][j] = $signed(hu[i]) * $signed(hp[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    h1_pt_reg[i][j] <= pr1[i][j][58:US];
                end
            end
            h1_v_reg <= d2_quo;
            h1_z_reg <= d2_side[236];
        end
    end

    // First Hamilton product: sums
    logic [3:0][3:0][T2W-1:0] h1_ext;
    logic [3:0][HW-1:0]     t_sum;
    logic [3:0][TW-1:0]     h2_t_reg;
    logic [3:0][UW-1:0]     h2_v_reg;
    logic                   h2_z_reg;
    logic                   h2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                h1_ext[i][j] = T2W'($signed(h1_pt_reg[i][j]));
            end
        end
        t_sum = hamilton(h1_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                h2_t_reg[i] <= t_sum[i][TW-1:0];
            end
            h2_v_reg <= h1_v_reg;
            h2_z_reg <= h1_z_reg;
        end
    end

    // Second Hamilton product t*v: partial products
    logic signed [63:0]     pr2 [0:3][0:3];
    logic [3:0][3:0][T2W-1:0] h3_pt_reg;
    logic                   h3_z_reg;
    logic                   h3_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pr2[i][j] = $signed(h2_t_reg[i]) * $signed(h2_v_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    h3_pt_reg[i][j] <= pr2[i][j][63:US];
                end
            end
            h3_z_reg <= h2_z_reg;
        end
    end

    // Second product sums, clamp to 32 bits, pick the fault code
    logic [3:0][HW-1:0]     res;
    logic [127:0]           data_next;
    logic [1:0]             fault_next;
    logic                   sat;

    always_comb
    begin
        res = hamilton(h3_pt_reg);
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if ($signed(res[i]) > SAT_HI)
            begin
                data_next[PW*i +: PW] = 32'h7FFF_FFFF;
                sat = 1'b1;
            end
            else if ($signed(res[i]) < SAT_LO)
            begin
                data_next[PW*i +: PW] = 32'h8000_0000;
                sat = 1'b1;
            end
            else
            begin
                data_next[PW*i +: PW] = res[i][PW-1:0];
            end
        end
        if (h3_z_reg)
        begin
            data_next  = '0;
            fault_next = qvr_pkg::FAULT_ZERO_NORM;
        end
        else if (sat)
        begin
            fault_next = qvr_pkg::FAULT_SATURATED;
        end
        else
        begin
            fault_next = qvr_pkg::FAULT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= data_next;
            out_fault_reg <= fault_next;
        end
    end

    // Advance valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            svld_reg      <= '0;
            sq_valid_reg  <= 1'b0;
            n_valid_reg   <= 1'b0;
            h1_valid_reg  <= 1'b0;
            h2_valid_reg  <= 1'b0;
            h3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg   <= cv;
            q_valid_reg   <= r_valid_reg;
            svld_reg      <= {svld_reg[SQS-1:0], q_valid_reg};
            sq_valid_reg  <= d1_valid;
            n_valid_reg   <= sq_valid_reg;
            h1_valid_reg  <= d2_valid;
            h2_valid_reg  <= h1_valid_reg;
            h3_valid_reg  <= h2_valid_reg;
            out_valid_reg <= h3_valid_reg;
        end
    end

endmodule

`default_nettype wire
